// ===== rtl/ps2kbd_pkg.sv =====
`default_nettype none
// ============================================================================
// ps2kbd_pkg - shared types and codes for the PS/2 keyboard responder
// Request and reply records, the decoded job record and the protocol bytes.
// ============================================================================

package ps2kbd_pkg;

    // Request from the upstream side: a host byte or a key event
    typedef struct packed {
        logic       cmd;
        logic [7:0] host_byte;
        logic [7:0] scan_code;
        logic [7:0] special_code;
        logic       extended;
        logic       release_req;
        logic       use_special;
    } req_t;

    // One reply byte toward the host
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
        logic       led_on;
        logic       kbd_enabled;
    } reply_t;

    // Decoded job: up to three bytes, sent from index 0 upward
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            led_on;
        logic            kbd_enabled;
    } job_t;

    // Request kinds
    localparam logic CMD_HOST = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    // Awaited argument codes
    localparam logic [1:0] ARG_NONE    = 2'd0;
    localparam logic [1:0] ARG_LEDS    = 2'd1;
    localparam logic [1:0] ARG_SCANSET = 2'd2;
    localparam logic [1:0] ARG_RATE    = 2'd3;

    // Host command codes
    localparam logic [7:0] HC_SET_LEDS  = 8'hED;
    localparam logic [7:0] HC_ECHO      = 8'hEE;
    localparam logic [7:0] HC_SCANSET   = 8'hF0;
    localparam logic [7:0] HC_IDENTIFY  = 8'hF2;
    localparam logic [7:0] HC_RATE      = 8'hF3;
    localparam logic [7:0] HC_ENABLE    = 8'hF4;
    localparam logic [7:0] HC_DISABLE   = 8'hF5;
    localparam logic [7:0] HC_DEFAULTS  = 8'hF6;
    localparam logic [7:0] HC_ALL_TYPM  = 8'hF7;
    localparam logic [7:0] HC_ALL_MB    = 8'hF8;
    localparam logic [7:0] HC_ALL_MAKE  = 8'hF9;
    localparam logic [7:0] HC_ALL_TMB   = 8'hFA;
    localparam logic [7:0] HC_RESEND    = 8'hFE;
    localparam logic [7:0] HC_RESET     = 8'hFF;

    // Device reply bytes
    localparam logic [7:0] BYTE_ACK    = 8'hFA;
    localparam logic [7:0] BYTE_BAT_OK = 8'hAA;
    localparam logic [7:0] BYTE_ECHO   = 8'hEE;
    localparam logic [7:0] BYTE_EXT    = 8'hE0;
    localparam logic [7:0] BYTE_BREAK  = 8'hF0;
    localparam logic [7:0] BYTE_ID_HI  = 8'hAB;
    localparam logic [7:0] BYTE_ID_LO  = 8'h83;
    localparam logic [7:0] BYTE_NONE   = 8'h00;

endpackage

`default_nettype wire

// ===== rtl/ps2kbd_device_responder.sv =====
`default_nettype none
// ============================================================================
// ps2_keyboard_device_responder - PS/2 keyboard device, byte level
// Answer host command bytes and report key events as scan-code bytes.
// ============================================================================
//
// Usage:
//   Request side works like a queue write port: drive req and raise push;
//   a request is taken at a clock edge with push high and full low. Each
//   request is a host byte (cmd = 0) or a key event (cmd = 1).
//   Reply side works like a queue read port: while empty is low, reply holds
//   the oldest reply byte; raise pop to take it. The final byte of each
//   request's run carries last = 1. Requests with no reply give no bytes.
//   A request's job passes the job queue and the sender's job register
//   before its first reply byte reaches the output register. Throughput:
//   one request per cycle on entry while full is low; the sender emits
//   one byte per cycle unless stalled, one to three bytes per reply.
//   A stalled reply side holds the output register; requests keep flowing
//   into the job queue (QUEUE_DEPTH jobs) until it fills and full rises.
//   Reset: reporting enabled, LED off, no argument awaited, queue and
//   output emptied. No power-on self-test byte is sent.
//
module ps2_keyboard_device_responder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire ps2kbd_pkg::req_t    req,
    output logic                     empty,
    input  wire logic                pop,
    output ps2kbd_pkg::reply_t       reply
);
    import ps2kbd_pkg::*;

    logic accept;
    logic job_valid;
    job_t front_job;
    job_t q_job;
    logic q_full, q_empty, q_pop;

    // accept a request only when the job queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    // decode requests and track enable, LED and awaited argument
    ps2kbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .job_valid (job_valid),
        .job       (front_job)
    );

    // hold decoded jobs so decode and send can stall apart
    ps2kbd_jobq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_valid),
        .wr_job  (front_job),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_job  (q_job),
        .q_empty (q_empty)
    );

    // advance through each job's bytes into the reply register
    ps2kbd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_job   (q_job),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .reply   (reply)
    );

endmodule

`default_nettype wire

// ===== rtl/ps2kbd_front.sv =====
`default_nettype none
// ============================================================================
// ps2kbd_front - request decoder
// Decode each request into a reply job and update enable, LED and argument.
// ============================================================================

module ps2kbd_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire ps2kbd_pkg::req_t  req,
    output logic                   job_valid,
    output ps2kbd_pkg::job_t       job
);
    import ps2kbd_pkg::*;

    logic       enabled_reg, enabled_next;
    logic       led_reg, led_next;
    logic [1:0] arg_reg, arg_next;
    logic [7:0] key_byte;

    assign key_byte = req.use_special ? req.special_code : req.scan_code;

    always_comb
    begin
        enabled_next = enabled_reg;
        led_next     = led_reg;
        arg_next     = arg_reg;
        job.cnt      = 2'd0;
        job.bytes    = {BYTE_NONE, BYTE_NONE, BYTE_NONE};

        if (req.cmd == CMD_HOST)
        begin
            if (arg_reg != ARG_NONE)
            begin
                // take the byte as argument, whatever its value
                if (arg_reg == ARG_LEDS)
                begin
                    led_next = (req.host_byte != 8'd0);
                end
                arg_next     = ARG_NONE;
                job.cnt      = 2'd1;
                job.bytes[0] = BYTE_ACK;
            end
            else
            begin
                case (req.host_byte)
                    HC_DISABLE:
                    begin
                        enabled_next = 1'b0;
                        job.cnt      = 2'd1;
                        job.bytes[0] = BYTE_ACK;
                    end
                    HC_ENABLE:
                    begin
                        enabled_next = 1'b1;
                        job.cnt      = 2'd1;
                        job.bytes[0] = BYTE_ACK;
                    end
                    HC_IDENTIFY:
                    begin
                        job.cnt      = 2'd3;
                        job.bytes[0] = BYTE_ACK;
                        job.bytes[1] = BYTE_ID_HI;
                        job.bytes[2] = BYTE_ID_LO;
                    end
                    HC_ECHO:
                    begin
                        job.cnt      = 2'd1;
                        job.bytes[0] = BYTE_ECHO;
                    end
                    HC_RESET:
                    begin
                        enabled_next = 1'b1;
                        led_next     = 1'b0;
                        arg_next     = ARG_NONE;
                        job.cnt      = 2'd2;
                        job.bytes[0] = BYTE_ACK;
                        job.bytes[1] = BYTE_BAT_OK;
                    end
                    HC_SET_LEDS:
                    begin
                        arg_next     = ARG_LEDS;
                        job.cnt      = 2'd1;
                        job.bytes[0] = BYTE_ACK;
                    end
                    HC_SCANSET:
                    begin
                        arg_next     = ARG_SCANSET;
                        job.cnt      = 2'd1;
                        job.bytes[0] = BYTE_ACK;
                    end
                    HC_RATE:
                    begin
                        arg_next     = ARG_RATE;
                        job.cnt      = 2'd1;
                        job.bytes[0] = BYTE_ACK;
                    end
                    HC_DEFAULTS, HC_ALL_TYPM, HC_ALL_MB, HC_ALL_MAKE,
                    HC_ALL_TMB, HC_RESEND:
                    begin
                        job.cnt      = 2'd1;
                        job.bytes[0] = BYTE_ACK;
                    end
                    default:
                    begin
                        job.cnt = 2'd0;
                    end
                endcase
            end
        end
        else if (enabled_reg && !(req.use_special && req.special_code == 8'd0))
        begin
            case ({req.extended, req.release_req})
                2'b00:
                begin
                    job.cnt      = 2'd1;
                    job.bytes[0] = key_byte;
                end
                2'b10:
                begin
                    job.cnt      = 2'd2;
                    job.bytes[0] = BYTE_EXT;
                    job.bytes[1] = key_byte;
                end
                2'b01:
                begin
                    job.cnt      = 2'd2;
                    job.bytes[0] = BYTE_BREAK;
                    job.bytes[1] = key_byte;
                end
                default:
                begin
                    job.cnt      = 2'd3;
                    job.bytes[0] = BYTE_EXT;
                    job.bytes[1] = BYTE_BREAK;
                    job.bytes[2] = key_byte;
                end
            endcase
        end

        job.led_on      = led_next;
        job.kbd_enabled = enabled_next;
    end

    // drop requests that give no reply
    assign job_valid = accept && (job.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
            led_reg     <= 1'b0;
            arg_reg     <= ARG_NONE;
        end
        else if (accept)
        begin
            enabled_reg <= enabled_next;
            led_reg     <= led_next;
            arg_reg     <= arg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ps2kbd_jobq.sv =====
`default_nettype none
// ============================================================================
// ps2kbd_jobq - job queue
// Small register queue between the decoder and the byte sender.
// ============================================================================

module ps2kbd_jobq #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire ps2kbd_pkg::job_t  wr_job,
    output logic                   q_full,
    input  wire logic              rd_en,
    output ps2kbd_pkg::job_t       rd_job,
    output logic                   q_empty
);
    import ps2kbd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    job_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign q_full  = (count_reg == CW'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ps2kbd_back.sv =====
`default_nettype none
// ============================================================================
// ps2kbd_back - byte sender
// Unroll jobs into bytes in an output register, one per cycle unless stalled.
// ============================================================================

module ps2kbd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ps2kbd_pkg::job_t  q_job,
    input  wire logic              q_empty,
    output logic                   q_pop,
    output logic                   empty,
    input  wire logic              pop,
    output ps2kbd_pkg::reply_t     reply
);
    import ps2kbd_pkg::*;

    job_t       job_reg;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    reply_t     out_reg, out_next;
    logic       out_free, emit, emit_last;
    logic [7:0] cur_byte;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_byte = job_reg.bytes[0];
            2'd1:    cur_byte = job_reg.bytes[1];
            default: cur_byte = job_reg.bytes[2];
        endcase
    end

    assign out_free  = !out_valid_reg || pop;
    assign emit      = busy_reg && out_free;
    assign emit_last = emit && (idx_reg == job_reg.cnt - 2'd1);
    assign q_pop     = (!busy_reg || emit_last) && !q_empty;

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;

        if (emit)
        begin
            out_valid_next      = 1'b1;
            out_next.tx_byte    = cur_byte;
            out_next.last       = emit_last;
            out_next.led_on     = job_reg.led_on;
            out_next.kbd_enabled = job_reg.kbd_enabled;
            idx_next            = idx_reg + 2'd1;
            if (emit_last)
            begin
                busy_next = 1'b0;
            end
        end

        if (q_pop)
        begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (q_pop)
        begin
            job_reg <= q_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty = !out_valid_reg;
    assign reply = out_reg;

endmodule

`default_nettype wire

// ===== tb/ps2_keyboard_device_responder_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// ps2_keyboard_device_responder_tb - self-checking bench for the responder
// Feeds host bytes and key events through the request queue port, predicts
// the reply bytes and state flags, and checks every reply popped.
// ============================================================================

module ps2_keyboard_device_responder_tb;

    import ps2kbd_pkg::*;

    // Scoreboard: tracks keyboard state and the reply bytes still owed
    class reply_scoreboard;
        logic       kbd_on;
        logic       led_lit;
        logic [1:0] awaited_arg;
        reply_t     owed_replies[$];
        int         mismatches;

        function new();
            kbd_on      = 1'b1;
            led_lit     = 1'b0;
            awaited_arg = ARG_NONE;
            mismatches  = 0;
        endfunction

        // Work out the reply run for one accepted request and queue it
        function void note_request(req_t r);
            logic [7:0] run_bytes[$];
            run_bytes = {};
            if (r.cmd == CMD_HOST)
            begin
                if (awaited_arg != ARG_NONE)
                begin
                    // Any byte completes the pending command, even a command code
                    if (awaited_arg == ARG_LEDS)
                        led_lit = (r.host_byte != BYTE_NONE);
                    awaited_arg = ARG_NONE;
                    run_bytes.push_back(BYTE_ACK);
                end
                else
                begin
                    case (r.host_byte)
                        HC_DISABLE:
                        begin
                            kbd_on = 1'b0;
                            run_bytes.push_back(BYTE_ACK);
                        end
                        HC_ENABLE:
                        begin
                            kbd_on = 1'b1;
                            run_bytes.push_back(BYTE_ACK);
                        end
                        HC_IDENTIFY:
                        begin
                            run_bytes.push_back(BYTE_ACK);
                            run_bytes.push_back(BYTE_ID_HI);
                            run_bytes.push_back(BYTE_ID_LO);
                        end
                        HC_ECHO:
                        begin
                            run_bytes.push_back(BYTE_ECHO);
                        end
                        HC_RESET:
                        begin
                            kbd_on      = 1'b1;
                            led_lit     = 1'b0;
                            awaited_arg = ARG_NONE;
                            run_bytes.push_back(BYTE_ACK);
                            run_bytes.push_back(BYTE_BAT_OK);
                        end
                        HC_SET_LEDS:
                        begin
                            awaited_arg = ARG_LEDS;
                            run_bytes.push_back(BYTE_ACK);
                        end
                        HC_SCANSET:
                        begin
                            awaited_arg = ARG_SCANSET;
                            run_bytes.push_back(BYTE_ACK);
                        end
                        HC_RATE:
                        begin
                            awaited_arg = ARG_RATE;
                            run_bytes.push_back(BYTE_ACK);
                        end
                        HC_DEFAULTS, HC_ALL_TYPM, HC_ALL_MB, HC_ALL_MAKE, HC_ALL_TMB,
                        HC_RESEND:
                        begin
                            run_bytes.push_back(BYTE_ACK);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            else if (kbd_on && !(r.use_special && r.special_code == BYTE_NONE))
            begin
                if (r.extended)
                    run_bytes.push_back(BYTE_EXT);
                if (r.release_req)
                    run_bytes.push_back(BYTE_BREAK);
                run_bytes.push_back(r.use_special ? r.special_code : r.scan_code);
            end
            foreach (run_bytes[i])
                owed_replies.push_back(reply_t'{
                    tx_byte:     run_bytes[i],
                    last:        (i == run_bytes.size() - 1) ? 1'b1 : 1'b0,
                    led_on:      led_lit,
                    kbd_enabled: kbd_on});
        endfunction

        // Compare one popped reply against the oldest owed one
        function void check_reply(reply_t got);
            reply_t want;
            if (owed_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected reply: byte %02h last %0b led %0b en %0b",
                             $time, got.tx_byte, got.last, got.led_on, got.kbd_enabled);
                return;
            end
            want = owed_replies.pop_front();
            if (got.tx_byte != want.tx_byte || got.last != want.last ||
                got.led_on != want.led_on || got.kbd_enabled != want.kbd_enabled)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] mismatch: want %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                             $time, want.tx_byte, want.last, want.led_on,
                             want.kbd_enabled, got.tx_byte, got.last, got.led_on,
                             got.kbd_enabled);
            end
        endfunction
    endclass

    // Every host code the keyboard answers
    localparam logic [7:0] KNOWN_HOST_CODES[15] = '{
        HC_SET_LEDS, HC_ECHO, HC_SCANSET, HC_IDENTIFY, HC_RATE, HC_ENABLE,
        HC_DISABLE, HC_DEFAULTS, HC_ALL_TYPM, HC_ALL_MB, HC_ALL_MAKE,
        HC_ALL_TMB, HC_RESEND, HC_RESET, HC_ENABLE};

    logic   clk;
    logic   rst_n;
    logic   push;
    logic   full;
    req_t   req;
    logic   empty;
    logic   pop;
    reply_t reply;

    reply_scoreboard sb = new();

    int pop_hold;    // cycles left to hold pop low
    bit no_idle;     // suppress gaps on both sides
    int leftover;

    ps2_keyboard_device_responder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .req   (req),
        .empty (empty),
        .pop   (pop),
        .reply (reply)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic req_t host_request(logic [7:0] b);
        req_t r;
        r              = req_t'(28'($urandom));
        r.cmd          = CMD_HOST;
        r.host_byte    = b;
        return r;
    endfunction

    function automatic req_t key_request(logic [7:0] code, logic [7:0] special,
                                         logic ext, logic rel, logic spec);
        req_t r;
        r              = req_t'(28'($urandom));
        r.cmd          = CMD_KEY;
        r.scan_code    = code;
        r.special_code = special;
        r.extended     = ext;
        r.release_req  = rel;
        r.use_special  = spec;
        return r;
    endfunction

    // Present one request from a falling edge, hold it until a rising edge
    // takes it with full low, then idle for a random gap
    task automatic send_request(req_t r);
        int gap;
        push <= 1'b1;
        req  <= r;
        do
            @(posedge clk);
        while (full);
        sb.note_request(r);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Reply side: drive pop at falling edges, holding it low during a stall
    initial
    begin
        pop      = 1'b0;
        pop_hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (pop_hold > 0)
            begin
                pop <= 1'b0;
                pop_hold--;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Take each reply at the rising edge that accepts it, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            sb.check_reply(reply);
            pop_hold = pick_gap();
        end
    end

    initial
    begin
        int         n_rand;
        int         roll;
        logic [7:0] special;

        rst_n   = 1'b0;
        push    = 1'b0;
        req     = '0;
        no_idle = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: plain make, longest run, missing special code
        send_request(key_request(8'h1C, 8'h00, 1'b0, 1'b0, 1'b0));
        send_request(key_request(8'hFF, 8'h55, 1'b1, 1'b1, 1'b0));
        send_request(key_request(8'h2A, 8'h00, 1'b1, 1'b1, 1'b1));
        // Zero and unknown host bytes give no reply; identify and echo
        send_request(host_request(BYTE_NONE));
        send_request(host_request(HC_IDENTIFY));
        send_request(host_request(HC_ECHO));
        send_request(host_request(8'hFB));
        // Key event in the middle of set-LEDs leaves the argument awaited;
        // then a command code taken as the argument turns the LED on
        send_request(host_request(HC_SET_LEDS));
        send_request(key_request(8'h00, 8'hFF, 1'b0, 1'b0, 1'b0));
        send_request(host_request(HC_RESET));
        // Disabled keyboard drops key events
        send_request(host_request(HC_DISABLE));
        send_request(key_request(8'h3C, 8'h77, 1'b1, 1'b0, 1'b0));
        send_request(host_request(HC_ENABLE));
        // Scan set and typematic arguments, zero and nonzero
        send_request(host_request(HC_SCANSET));
        send_request(host_request(BYTE_NONE));
        send_request(host_request(HC_RATE));
        send_request(host_request(8'h7F));
        // Flag commands and resend: ack only
        send_request(host_request(HC_DEFAULTS));
        send_request(host_request(HC_ALL_TYPM));
        send_request(host_request(HC_ALL_MB));
        send_request(host_request(HC_ALL_MAKE));
        send_request(host_request(HC_ALL_TMB));
        send_request(host_request(HC_RESEND));
        // Reset clears state; then a special-code break with prefix
        send_request(host_request(HC_RESET));
        send_request(key_request(8'h11, 8'h80, 1'b1, 1'b1, 1'b1));

        // Random: first stretch back to back on both sides, then with gaps
        no_idle = 1'b1;
        for (n_rand = 0; n_rand < 95; n_rand++)
        begin
            if (n_rand == 40)
                no_idle = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 30)
            begin
                send_request(host_request(KNOWN_HOST_CODES[$urandom_range(0, 14)]));
            end
            else if (roll < 45)
            begin
                send_request(host_request(8'($urandom)));
            end
            else
            begin
                special = ($urandom_range(0, 3) == 0) ? BYTE_NONE : 8'($urandom);
                send_request(key_request(8'($urandom), special, 1'($urandom),
                                         1'($urandom), 1'($urandom)));
            end
        end
        push <= 1'b0;

        // Drain: keep pop high and let the pipeline settle
        no_idle = 1'b1;
        while (sb.owed_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        leftover = sb.owed_replies.size();
        if (sb.mismatches == 0 && leftover == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
